// ===== src/swr_pkg.sv =====
`default_nettype none
package swr_pkg;

  localparam int MAX_TEXT_LEN = 4096;
  localparam int POS_W        = $clog2(MAX_TEXT_LEN);
  localparam int CODE_W       = 7;
  localparam int GW           = 8;
  localparam int RW_W         = 13;
  localparam int FIELD_W      = 12;
  localparam int CFG_W        = 12;
  localparam int TBL_DEPTH    = 128;
  localparam int RES_MAX      = 2;
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_AW        = $clog2(OQ_DEPTH);
  localparam int OQ_CW        = OQ_AW + 1;

  localparam logic [CFG_W-1:0]  CFG_RESET = 12'd720;
  localparam logic [CODE_W-1:0] NEWLINE   = 7'd10;
  localparam logic [CODE_W-1:0] SPACE     = 7'd32;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CHAR = 2'd1,
    OP_END  = 2'd2
  } op_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] wid;
    logic               has;
    logic               last;
  } line_t;

  typedef struct packed {
    logic [1:0] n;
    line_t      r0;
    line_t      r1;
  } push_t;

  typedef struct packed {
    logic [OQ_CW-1:0] count;
    logic             empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== src/subtitle_word_wrap_core.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_op, in_char_code, in_glyph_width
// out       out_valid / out_ready     out_line_start/_length/_width, out_has_line, out_is_last
// cfg       cfg_we                    cfg_wdata (max_line_width)
//
// One input beat per cycle while in_ready is high. A beat reads the glyph table as
// it is accepted, is wrapped from the registered read and lands in an 8-entry
// result queue. Reset is synchronous and clears the text state,
// the glyph table (per-entry valid bits) and the queue at once. in_ready drops
// only while the queue lacks room for two results of each beat in flight.
module subtitle_word_wrap_core import swr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [GW-1:0]      in_glyph_width,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [FIELD_W-1:0]      out_line_start,
  output logic [FIELD_W-1:0]      out_line_length,
  output logic [FIELD_W-1:0]      out_line_width,
  output logic                    out_has_line,
  output logic                    out_is_last
);

  logic [CFG_W-1:0]     max_r;
  logic [TBL_DEPTH-1:0] tv_r;
  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [CODE_W-1:0]    s1_char_r;
  logic                 s1_hit_r;
  logic [GW-1:0]        tbl_rdata;
  logic [GW-1:0]        s1_w;
  logic [CODE_W-1:0]    idx;
  logic                 accept;
  logic                 load_acc;
  logic [OQ_CW:0]       need;
  push_t                push;
  line_t                head;
  q_stat_t              q_stat;

  assign idx      = in_char_code[CODE_W-1:0];
  assign accept   = in_valid && in_ready;
  assign load_acc = accept && (in_op == OP_LOAD);

  // room for the beat in the wrap stage plus the one taken now
  assign need = {1'b0, q_stat.count}
              + (s1_valid_r ? (OQ_CW+1)'(RES_MAX) : '0)
              + (OQ_CW+1)'(RES_MAX);
  assign in_ready = need <= (OQ_CW+1)'(OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= CFG_RESET;
      tv_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (load_acc) begin
        tv_r[idx] <= 1'b1;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_op;
      s1_char_r <= idx;
      s1_hit_r  <= tv_r[idx];
    end
  end

  swr_ram #(
    .WIDTH (GW),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (load_acc),
    .waddr (idx),
    .wdata (in_glyph_width),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  // entries never loaded since reset read as zero width
  assign s1_w = s1_hit_r ? tbl_rdata : '0;

  swr_wrap u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_op    (s1_op_r),
    .s1_char  (s1_char_r),
    .s1_w     (s1_w),
    .max_w    (max_r),
    .push     (push)
  );

  swr_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop_req (out_ready),
    .head    (head),
    .stat    (q_stat)
  );

  assign out_valid       = !q_stat.empty;
  assign out_line_start  = head.start;
  assign out_line_length = head.len;
  assign out_line_width  = head.wid;
  assign out_has_line    = head.has;
  assign out_is_last     = head.last;

`ifndef NO_ASSERTIONS
  a_end_one: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_op_r == OP_END) |-> push.n == 2'd1)
    else $error("end of text did not give exactly one result");

  a_two_char: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (s1_valid_r && s1_op_r == OP_CHAR))
    else $error("double result from a non-character beat");

  a_no_idle_push: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> push.n == 2'd0)
    else $error("result pushed with no beat in the wrap stage");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

// ===== src/swr_ram.sv =====
`default_nettype none
module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== src/swr_wrap.sv =====
`default_nettype none
module swr_wrap import swr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire logic [1:0]        s1_op,
  input  wire logic [CODE_W-1:0] s1_char,
  input  wire logic [GW-1:0]     s1_w,
  input  wire logic [CFG_W-1:0]  max_w,
  output push_t                  push
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ls_r, ls_nxt;
  logic [POS_W-1:0] ws_r, ws_nxt;
  logic [RW_W-1:0]  rw_r, rw_nxt;
  logic [RW_W-1:0]  wbw_r, wbw_nxt;

  logic [RW_W:0]    sum_full;
  logic [RW_W-1:0]  tail;
  logic [RW_W:0]    sum_tail;
  logic             over_line;
  logic             over_word;
  logic             text_full;
  logic [POS_W-1:0] pos_inc;

  function automatic line_t mk(logic [POS_W-1:0] s, logic [POS_W-1:0] l,
                               logic [RW_W-1:0] wd, logic h, logic la);
    line_t r;
    r.start = FIELD_W'(s);
    r.len   = FIELD_W'(l);
    r.wid   = FIELD_W'(wd);
    r.has   = h;
    r.last  = la;
    return r;
  endfunction

  assign pos_inc   = pos_r + 1'b1;
  assign text_full = pos_r >= POS_W'(MAX_TEXT_LEN - 1);
  assign sum_full  = {1'b0, rw_r} + (RW_W+1)'(s1_w);
  assign over_line = (pos_r != ls_r) && (sum_full > (RW_W+1)'(max_w));
  assign tail      = rw_r - wbw_r;
  assign sum_tail  = {1'b0, tail} + (RW_W+1)'(s1_w);
  assign over_word = (pos_r != ws_r) && (sum_tail > (RW_W+1)'(max_w));

  always_comb begin
    logic [POS_W-1:0] ls2;
    logic [RW_W-1:0]  rw2;
    logic [RW_W-1:0]  rw3;
    pos_nxt = pos_r;
    ls_nxt  = ls_r;
    ws_nxt  = ws_r;
    rw_nxt  = rw_r;
    wbw_nxt = wbw_r;
    push    = '0;
    ls2     = ls_r;
    rw2     = rw_r;
    rw3     = '0;
    if (s1_valid) begin
      unique case (s1_op)
        OP_END: begin
          push.n = 2'd1;
          if (pos_r != ls_r) begin
            push.r0 = mk(ls_r, pos_r - ls_r, rw_r, 1'b1, 1'b1);
          end else begin
            push.r0 = mk('0, '0, '0, 1'b0, 1'b1);
          end
          pos_nxt = '0;
          ls_nxt  = '0;
          ws_nxt  = '0;
          rw_nxt  = '0;
          wbw_nxt = '0;
        end
        OP_CHAR: begin
          if (!text_full) begin
            if (s1_char == NEWLINE) begin
              push.n  = 2'd1;
              push.r0 = mk(ls_r, pos_r - ls_r, rw_r, 1'b1, 1'b0);
              pos_nxt = pos_inc;
              ls_nxt  = pos_inc;
              ws_nxt  = pos_inc;
              rw_nxt  = '0;
              wbw_nxt = '0;
            end else begin
              ws_nxt  = ws_r;
              wbw_nxt = wbw_r;
              if (over_line) begin
                push.n = 2'd1;
                if (ws_r != ls_r) begin
                  // break at the last word start, keep the trailing space
                  push.r0 = mk(ls_r, ws_r - ls_r, wbw_r, 1'b1, 1'b0);
                  if (over_word) begin
                    push.n  = 2'd2;
                    push.r1 = mk(ws_r, pos_r - ws_r, tail, 1'b1, 1'b0);
                    ls2     = pos_r;
                    rw2     = '0;
                  end else begin
                    ls2 = ws_r;
                    rw2 = tail;
                  end
                end else begin
                  push.r0 = mk(ls_r, pos_r - ls_r, rw_r, 1'b1, 1'b0);
                  ls2     = pos_r;
                  rw2     = '0;
                end
                ws_nxt  = ls2;
                wbw_nxt = '0;
              end
              rw3     = rw2 + RW_W'(s1_w);
              ls_nxt  = ls2;
              rw_nxt  = rw3;
              pos_nxt = pos_inc;
              if (s1_char == SPACE) begin
                ws_nxt  = pos_inc;
                wbw_nxt = rw3;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ls_r  <= '0;
      ws_r  <= '0;
      rw_r  <= '0;
      wbw_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ls_r  <= ls_nxt;
      ws_r  <= ws_nxt;
      rw_r  <= rw_nxt;
      wbw_r <= wbw_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/swr_outq.sv =====
`default_nettype none
module swr_outq import swr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  push_t      push,
  input  wire logic  pop_req,
  output line_t      head,
  output q_stat_t    stat
);

  line_t            mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt;
  logic [OQ_AW-1:0] rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_AW-1:0] wp1;
  logic             pop;

  assign wp1        = wp_r + 1'b1;
  assign pop        = pop_req && (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = wp_r + OQ_AW'(push.n);
    rp_nxt  = rp_r + OQ_AW'(pop);
    cnt_nxt = cnt_r + OQ_CW'(push.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== dv/subtitle_word_wrap_core_tb.sv =====
`timescale 1ns / 100ps
module subtitle_word_wrap_core_tb import swr_pkg::*; ;

  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [7:0]  CH_A        = "A";
  localparam logic [7:0]  CH_M        = "M";
  localparam logic [7:0]  CH_W        = "W";
  localparam logic [7:0]  CH_Z        = "Z";
  localparam logic [7:0]  LC_FIRST    = "a";
  localparam logic [7:0]  LC_LAST     = "z";

  typedef struct {
    logic [1:0] op;
    logic [7:0] code;
    logic [7:0] gw;
  } text_beat_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata      = '0;
  logic               in_valid       = 1'b0;
  logic [1:0]         in_op          = '0;
  logic [7:0]         in_char_code   = '0;
  logic [GW-1:0]      in_glyph_width = '0;
  logic               out_ready      = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [FIELD_W-1:0] out_line_start;
  logic [FIELD_W-1:0] out_line_length;
  logic [FIELD_W-1:0] out_line_width;
  logic               out_has_line;
  logic               out_is_last;

  subtitle_word_wrap_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_char_code    (in_char_code),
    .in_glyph_width  (in_glyph_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_start  (out_line_start),
    .out_line_length (out_line_length),
    .out_line_width  (out_line_width),
    .out_has_line    (out_has_line),
    .out_is_last     (out_is_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // wrap state mirrored from the block
  logic [GW-1:0]      glyph_w [TBL_DEPTH] = '{default: '0};
  logic [CFG_W-1:0]   max_w    = CFG_RESET;
  logic [POS_W-1:0]   txt_pos  = '0;
  logic [POS_W-1:0]   ln_start = '0;
  logic [POS_W-1:0]   wd_start = '0;
  logic [RW_W-1:0]    run_w    = '0;
  logic [RW_W-1:0]    w_before = '0;

  text_beat_t  text_beats [$];
  line_t       pending_lines [$];
  int unsigned beats_queued = 0;
  int unsigned lines_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  task automatic expect_line(input logic [FIELD_W-1:0] s, input logic [FIELD_W-1:0] n,
                             input logic [RW_W-1:0] wd, input logic h, input logic la);
    line_t l;
    l.start = s;
    l.len   = n;
    l.wid   = wd[FIELD_W-1:0];
    l.has   = h;
    l.last  = la;
    pending_lines.push_back(l);
  endtask

  task automatic wrap_beat(input logic [1:0] op, input logic [7:0] code,
                           input logic [GW-1:0] gw);
    logic [CODE_W-1:0] c;
    logic [RW_W-1:0]   w;
    logic [RW_W-1:0]   tail;
    c = code[CODE_W-1:0];
    case (op)
      OP_LOAD: glyph_w[c] = gw;
      OP_END: begin
        if (txt_pos != ln_start)
          expect_line(ln_start, txt_pos - ln_start, run_w, 1'b1, 1'b1);
        else
          expect_line('0, '0, '0, 1'b0, 1'b1);
        txt_pos  = '0;
        ln_start = '0;
        wd_start = '0;
        run_w    = '0;
        w_before = '0;
      end
      OP_CHAR: if (txt_pos < MAX_TEXT_LEN - 1) begin
        if (c == NEWLINE) begin
          expect_line(ln_start, txt_pos - ln_start, run_w, 1'b1, 1'b0);
          ln_start = txt_pos + 1'b1;
          wd_start = txt_pos + 1'b1;
          run_w    = '0;
          w_before = '0;
        end else begin
          w = glyph_w[c];
          if (txt_pos != ln_start && run_w + w > max_w) begin
            if (wd_start != ln_start) begin
              // break at the last word start, then retry with the word's tail
              tail = run_w - w_before;
              expect_line(ln_start, wd_start - ln_start, w_before, 1'b1, 1'b0);
              ln_start = wd_start;
              run_w    = tail;
              if (txt_pos != ln_start && tail + w > max_w) begin
                expect_line(ln_start, txt_pos - ln_start, tail, 1'b1, 1'b0);
                ln_start = txt_pos;
                run_w    = '0;
              end
            end else begin
              expect_line(ln_start, txt_pos - ln_start, run_w, 1'b1, 1'b0);
              ln_start = txt_pos;
              run_w    = '0;
            end
            wd_start = ln_start;
            w_before = '0;
          end
          run_w = run_w + w;
          if (c == SPACE) begin
            wd_start = txt_pos + 1'b1;
            w_before = run_w;
          end
        end
        txt_pos = txt_pos + 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic push_beat(input logic [1:0] op, input logic [7:0] code, input logic [7:0] gw);
    text_beat_t b;
    b = '{op, code, gw};
    text_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic reload_table(input int unsigned cap, input int unsigned n);
    logic [7:0] code;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        code = {7'd0, 1'b0} | SPACE;
      else if ($urandom_range(0, 5) == 0)
        code = 8'($urandom_range(0, 255));
      else
        code = 8'($urandom_range(LC_FIRST, LC_LAST));
      push_beat(OP_LOAD, code, 8'($urandom_range(0, cap)));
    end
  endtask

  // mostly words and spaces, with newlines, stray codes, spare opcodes and table updates mixed in
  task automatic add_text(input int unsigned goal, input int unsigned cap);
    int unsigned sent;
    int unsigned k;
    int unsigned len;
    sent = 0;
    while (sent < goal) begin
      k = $urandom_range(0, 99);
      if (k < 3) begin
        push_beat(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, cap)));
      end else if (k < 5) begin
        push_beat(OP_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (k < 9) begin
        push_beat(OP_CHAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sent++;
      end else if (k < 14) begin
        push_beat(OP_CHAR, {1'($urandom_range(0, 1)), NEWLINE}, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len)
          push_beat(OP_CHAR, 8'($urandom_range(LC_FIRST, LC_LAST)) |
                    {1'($urandom_range(0, 1)), 7'd0}, 8'($urandom_range(0, 255)));
        sent += len;
        if ($urandom_range(0, 9) != 0) begin
          push_beat(OP_CHAR, {1'b0, SPACE}, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
    push_beat(OP_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (text_beats.size() != 0 || in_valid || pending_lines.size() != 0)
      @(negedge clk);
    // beats that give no line may still sit in the pipeline
    repeat (4) @(negedge clk);
  endtask

  task automatic set_line_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_w = v;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // sender: bursts of beats separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : beat_driver
    text_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        wrap_beat(in_op, in_char_code, in_glyph_width);
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || text_beats.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0)
            gap_left <= gap_left - 1;
        end else begin
          nxt = text_beats.pop_front();
          in_valid       <= 1'b1;
          in_op          <= nxt.op;
          in_char_code   <= nxt.code;
          in_glyph_width <= nxt.gw;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern is picked anew whenever its random run ends, plus one long hold
  int unsigned hold_left  = 0;
  bit          held_once  = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;

  always @(posedge clk) begin : line_receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held_once && in_valid && lines_seen >= 200) begin
      held_once <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= mode_left[0];
      endcase
    end
  end

  always @(posedge clk) begin : line_monitor
    line_t want;
    if (rst_n && out_valid && out_ready) begin
      lines_seen <= lines_seen + 1;
      if (pending_lines.size() == 0) begin
        mismatches++;
        $display("%0t: line expected none, got start %0d length %0d width %0d", $time,
                 out_line_start, out_line_length, out_line_width);
      end else begin
        want = pending_lines.pop_front();
        check_field("line_start", want.start, out_line_start);
        check_field("line_length", want.len, out_line_length);
        check_field("line_width", want.wid, out_line_width);
        check_field("has_line", want.has, out_has_line);
        check_field("is_last", want.last, out_is_last);
      end
    end
  end

  // worst case is every beat giving up to two lines behind a slow receiver
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("subtitle_word_wrap_core_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] limits [5];
    int unsigned      caps [5];
    int unsigned      mark;
    limits = '{12'd45, 12'd1, 12'd720, 12'd4095, 12'd0};
    caps   = '{12, 3, 40, 255, 0};
    limits[4] = CFG_W'($urandom_range(2, 4094));
    caps[4]   = $urandom_range(1, 255);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: narrow limit to hit the break paths that give one line
    set_line_limit(12'd20);
    push_beat(OP_CHAR, CH_A, 8'd0);
    push_beat(OP_LOAD, CH_A, 8'd6);
    push_beat(OP_LOAD, {1'b0, SPACE}, 8'd3);
    push_beat(OP_LOAD, CH_M, 8'd11);
    push_beat(OP_LOAD, CH_W, 8'd255);
    push_beat(OP_LOAD, 8'h00, 8'd5);
    push_beat(OP_LOAD, 8'hFF, 8'd2);
    push_beat(OP_END, 8'h00, 8'h00);
    push_beat(OP_SPARE, 8'hFF, 8'hFF);
    push_beat(OP_CHAR, CH_W, 8'h00);
    push_beat(OP_CHAR, CH_A, 8'h00);
    push_beat(OP_CHAR, CH_A, 8'h00);
    push_beat(OP_CHAR, {1'b0, SPACE}, 8'h00);
    push_beat(OP_CHAR, CH_M, 8'h00);
    push_beat(OP_CHAR, CH_M, 8'h00);
    push_beat(OP_CHAR, 8'h00, 8'hFF);
    push_beat(OP_CHAR, 8'h80, 8'h00);
    push_beat(OP_CHAR, {1'b0, NEWLINE}, 8'h00);
    push_beat(OP_CHAR, {1'b0, NEWLINE}, 8'h00);
    push_beat(OP_CHAR, {1'b1, NEWLINE}, 8'h00);
    push_beat(OP_CHAR, 8'hFF, 8'h00);
    push_beat(OP_CHAR, CH_Z, 8'h00);
    push_beat(OP_END, 8'hFF, 8'hFF);

    for (int p = 0; p < 5; p++) begin
      set_line_limit(limits[p]);
      if (p == 0) begin
        for (int i = 0; i < TBL_DEPTH; i++)
          push_beat(OP_LOAD, {1'($urandom_range(0, 1)), 7'(i)}, 8'($urandom_range(0, 24)));
      end else begin
        reload_table(caps[p], 24);
      end
      mark = beats_queued;
      while (beats_queued - mark < 180)
        add_text($urandom_range(0, 60), caps[p]);
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (mismatches == 0)
      $display("subtitle_word_wrap_core_tb: done, clean");
    else
      $display("subtitle_word_wrap_core_tb: done, errors");
    $finish;
  end

endmodule
